// ===== hw/rtl/mbca_pkg.sv =====
// ----------------------------------------------------------------------------
// mbca_pkg
// Shared types and constants of the multichannel boxcar averager.
// ----------------------------------------------------------------------------
`default_nettype none

package mbca_pkg;

   localparam int CHANNELS_DEFAULT = 5;
   localparam int SCANS_DEFAULT    = 35;

   localparam int SAMPLE_W = 16;
   localparam int SLOT_W   = 3;
   localparam int KIND_W   = 2;
   localparam int REQ_DATA_W = 24;   // sample_value + slot, padded to bytes
   localparam int RSP_DATA_W = 24;   // average_value + two flags, padded

   typedef enum logic [KIND_W-1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_READ   = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   // status that travels with a read through the divide pipeline
   typedef struct packed {
      logic ready_res;
      logic slot_bad;
   } rd_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mbca_cell.sv =====
// ----------------------------------------------------------------------------
// mbca_cell
// One sample position of the boxcar delay line; passes its sample on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module mbca_cell (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            shift_en,
   input  wire logic [mbca_pkg::SAMPLE_W-1:0]   sample_in,
   output logic      [mbca_pkg::SAMPLE_W-1:0]   sample_out
);

   logic [mbca_pkg::SAMPLE_W-1:0] sample_ff;
   logic [mbca_pkg::SAMPLE_W-1:0] sample_in_sel;

   always_comb begin
      sample_in_sel = shift_en ? sample_in : sample_ff;
   end

   // store starts out as zeros
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in_sel;
      end
   end

   assign sample_out = sample_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mbca_divider.sv =====
// ----------------------------------------------------------------------------
// mbca_divider
// Divides a channel sum by SCANS: reciprocal multiply stage and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbca_divider #(
   parameter int SUM_W = 22,
   parameter int SCANS = mbca_pkg::SCANS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   output logic                                 in_ready,
   input  wire logic [SUM_W-1:0]                in_sum,
   input  wire mbca_pkg::rd_ctl_type            in_ctl,
   output logic                                 out_valid,
   input  wire logic                            out_ready,
   output logic      [mbca_pkg::SAMPLE_W-1:0]   out_average,
   output mbca_pkg::rd_ctl_type                 out_ctl
);

   // exact for every SUM_W-bit dividend: m = ceil(2^(N+l) / d), l = ceil(log2 d)
   localparam int              SHIFT_L = $clog2(SCANS);
   localparam int              SHIFT_K = SUM_W + SHIFT_L;
   localparam int              RECIP_W = SUM_W + 1;
   localparam int              PROD_W  = SUM_W + RECIP_W;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << SHIFT_K) + 64'(SCANS) - 64'd1) / 64'(SCANS);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

   logic                          prod_valid_ff, prod_valid_in;
   logic [PROD_W-1:0]             prod_ff, prod_in;
   mbca_pkg::rd_ctl_type          prod_ctl_ff, prod_ctl_in;
   logic                          out_valid_ff, out_valid_in;
   logic [mbca_pkg::SAMPLE_W-1:0] avg_ff, avg_in;
   mbca_pkg::rd_ctl_type          out_ctl_ff, out_ctl_in;
   logic                          out_adv;
   logic                          prod_adv;

   always_comb begin
      out_adv  = !out_valid_ff || out_ready;
      prod_adv = !prod_valid_ff || out_adv;

      prod_valid_in = prod_valid_ff;
      prod_in       = prod_ff;
      prod_ctl_in   = prod_ctl_ff;
      if (prod_adv) begin
         prod_valid_in = in_valid;
         prod_in       = PROD_W'(in_sum) * PROD_W'(RECIP);
         prod_ctl_in   = in_ctl;
      end

      out_valid_in = out_valid_ff;
      avg_in       = avg_ff;
      out_ctl_in   = out_ctl_ff;
      if (out_adv) begin
         out_valid_in = prod_valid_ff;
         avg_in       = prod_ff[SHIFT_K +: mbca_pkg::SAMPLE_W];
         out_ctl_in   = prod_ctl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      prod_ctl_ff <= prod_ctl_in;
      avg_ff      <= avg_in;
      out_ctl_ff  <= out_ctl_in;
   end

   assign in_ready    = prod_adv;
   assign out_valid   = out_valid_ff;
   assign out_average = avg_ff;
   assign out_ctl     = out_ctl_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/multichannel_boxcar_averager.sv =====
// ----------------------------------------------------------------------------
// multichannel_boxcar_averager
// Per-channel moving average over the last SCANS scans of one converter.
// ----------------------------------------------------------------------------
// Takes one request per clock unless responses stall. Samples shift into a
// delay line of CHANNELS*SCANS cells; the cell falling off the end is the
// sample being replaced, and a ring of CHANNELS running sums rotates with each
// sample so the current channel's sum always sits at the head. A read request
// passes through the sum select, reciprocal multiply and output registers, and
// reads stream at one per cycle unless responses stall; samples and error
// events produce no response. The store is all zeros right out of reset, with
// no clearing pass. ready_res goes high after the first full pass through the
// store and drops on an error event until the next pass completes.
`default_nettype none

module multichannel_boxcar_averager #(
   parameter int CHANNELS = mbca_pkg::CHANNELS_DEFAULT,
   parameter int SCANS    = mbca_pkg::SCANS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [mbca_pkg::REQ_DATA_W-1:0]    req_tdata,  // sample_value, slot
   input  wire logic [mbca_pkg::KIND_W-1:0]        req_tuser,  // kind
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic      [mbca_pkg::RSP_DATA_W-1:0]    rsp_tdata   // average_value,
                                                               // ready_res, slot_bad
);

   localparam int DEPTH = CHANNELS * SCANS;
   localparam int SUM_W = mbca_pkg::SAMPLE_W + $clog2(SCANS + 1);
   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SC_W  = (SCANS > 1) ? $clog2(SCANS) : 1;
   localparam int IX_W  = mbca_pkg::SLOT_W + 1;

   localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);
   localparam logic [SC_W-1:0] LAST_SC = SC_W'(SCANS - 1);
   localparam logic [IX_W-1:0] NUM_CH  = IX_W'(CHANNELS);

   logic                             req_accept;
   mbca_pkg::kind_type               req_kind;
   logic [mbca_pkg::SAMPLE_W-1:0]    req_sample;
   logic [mbca_pkg::SLOT_W-1:0]      req_slot;
   logic                             sample_take;

   logic [mbca_pkg::SAMPLE_W-1:0]    chain [DEPTH+1];

   logic [SUM_W-1:0]                 sum_ff [CHANNELS];
   logic [SUM_W-1:0]                 sum_in [CHANNELS];
   logic [SUM_W-1:0]                 head_sum;
   logic [CH_W-1:0]                  ch_pos_ff, ch_pos_in;
   logic [SC_W-1:0]                  sc_pos_ff, sc_pos_in;
   logic                             primed_ff, primed_in;
   logic                             faulted_ff, faulted_in;
   logic                             wrap;

   logic [IX_W-1:0]                  slot_ext;
   logic                             slot_ok;
   logic [IX_W-1:0]                  ring_raw;
   logic [IX_W-1:0]                  ring_ix;
   logic [SUM_W-1:0]                 read_sum;

   logic                             sel_valid_ff, sel_valid_in;
   logic [SUM_W-1:0]                 sel_sum_ff, sel_sum_in;
   mbca_pkg::rd_ctl_type             sel_ctl_ff, sel_ctl_in;
   logic                             sel_adv;
   logic                             div_ready;

   logic                             rsp_valid;
   logic [mbca_pkg::SAMPLE_W-1:0]    rsp_average;
   mbca_pkg::rd_ctl_type             rsp_ctl;

   assign req_kind    = mbca_pkg::kind_type'(req_tuser);
   assign req_sample  = req_tdata[mbca_pkg::SAMPLE_W-1:0];
   assign req_slot    = req_tdata[mbca_pkg::SAMPLE_W +: mbca_pkg::SLOT_W];
   assign req_accept  = req_tvalid && req_tready;
   assign sample_take = req_accept && (req_kind == mbca_pkg::KIND_SAMPLE);

   // delay line: chain[DEPTH] is the sample written one full store ago
   assign chain[0] = req_sample;
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      mbca_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (sample_take),
         .sample_in  (chain[i]),
         .sample_out (chain[i+1])
      );
   end

   // sum ring: sum_ff[i] belongs to channel (ch_pos + i) mod CHANNELS
   always_comb begin
      head_sum = sum_ff[0] - SUM_W'(chain[DEPTH]) + SUM_W'(req_sample);
      for (int i = 0; i < CHANNELS; i++) begin
         sum_in[i] = sum_ff[i];
      end
      if (sample_take) begin
         for (int i = 0; i < CHANNELS - 1; i++) begin
            sum_in[i] = sum_ff[i+1];
         end
         sum_in[CHANNELS-1] = head_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i] <= sum_in[i];
         end
      end
   end

   always_comb begin
      ch_pos_in  = ch_pos_ff;
      sc_pos_in  = sc_pos_ff;
      primed_in  = primed_ff;
      faulted_in = faulted_ff;
      wrap       = (ch_pos_ff == LAST_CH) && (sc_pos_ff == LAST_SC);
      case (req_kind)
         mbca_pkg::KIND_SAMPLE: begin
            if (req_accept) begin
               if (ch_pos_ff == LAST_CH) begin
                  ch_pos_in = '0;
                  sc_pos_in = (sc_pos_ff == LAST_SC) ? '0 : sc_pos_ff + 1'b1;
               end else begin
                  ch_pos_in = ch_pos_ff + 1'b1;
               end
               if (wrap) begin
                  primed_in  = 1'b1;
                  faulted_in = 1'b0;
               end
            end
         end
         mbca_pkg::KIND_ERROR: begin
            if (req_accept) begin
               faulted_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_pos_ff  <= '0;
         sc_pos_ff  <= '0;
         primed_ff  <= 1'b0;
         faulted_ff <= 1'b0;
      end else begin
         ch_pos_ff  <= ch_pos_in;
         sc_pos_ff  <= sc_pos_in;
         primed_ff  <= primed_in;
         faulted_ff <= faulted_in;
      end
   end

   // ring position of the requested slot
   always_comb begin
      slot_ext = IX_W'(req_slot);
      slot_ok  = slot_ext < NUM_CH;
      ring_raw = slot_ext + NUM_CH - IX_W'(ch_pos_ff);
      ring_ix  = (ring_raw >= NUM_CH) ? ring_raw - NUM_CH : ring_raw;
      read_sum = slot_ok ? sum_ff[ring_ix[CH_W-1:0]] : '0;
   end

   // select stage
   always_comb begin
      sel_adv      = !sel_valid_ff || div_ready;
      sel_valid_in = sel_valid_ff;
      sel_sum_in   = sel_sum_ff;
      sel_ctl_in   = sel_ctl_ff;
      if (sel_adv) begin
         sel_valid_in         = req_accept && (req_kind == mbca_pkg::KIND_READ);
         sel_sum_in           = read_sum;
         sel_ctl_in.ready_res = primed_ff && !faulted_ff;
         sel_ctl_in.slot_bad  = !slot_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
      end else begin
         sel_valid_ff <= sel_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_sum_ff <= sel_sum_in;
      sel_ctl_ff <= sel_ctl_in;
   end

   assign req_tready = sel_adv;

   mbca_divider #(
      .SUM_W (SUM_W),
      .SCANS (SCANS)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (sel_valid_ff),
      .in_ready    (div_ready),
      .in_sum      (sel_sum_ff),
      .in_ctl      (sel_ctl_ff),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_tready),
      .out_average (rsp_average),
      .out_ctl     (rsp_ctl)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = {{(mbca_pkg::RSP_DATA_W - mbca_pkg::SAMPLE_W - 2){1'b0}},
                        rsp_ctl.slot_bad, rsp_ctl.ready_res, rsp_average};

   // ------------------------------------------------------------------------
   a_ch_range: assert property (@(posedge clock) disable iff (reset)
      ch_pos_ff <= LAST_CH)
      else $error("channel position out of range");

   a_sc_range: assert property (@(posedge clock) disable iff (reset)
      sc_pos_ff <= LAST_SC)
      else $error("scan position out of range");

   a_wrap_primes: assert property (@(posedge clock) disable iff (reset)
      (sample_take && wrap) |=> (primed_ff && !faulted_ff
                                 && ch_pos_ff == '0 && sc_pos_ff == '0))
      else $error("store pass did not set ready state");

   a_bad_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_ctl.slot_bad) |-> (rsp_average == '0))
      else $error("bad slot response carries nonzero average");

   a_error_faults: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_kind == mbca_pkg::KIND_ERROR) |=> faulted_ff)
      else $error("error event did not set fault");

endmodule

`default_nettype wire
